>>> design/barcode_whitelist_hamming_match_core_assert.svh
// assertion macros for the barcode whitelist matcher
// expects clk and rst_n in the scope of the including module
`ifndef BARCODE_WHITELIST_HAMMING_MATCH_CORE_ASSERT_SVH
`define BARCODE_WHITELIST_HAMMING_MATCH_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BWHM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BWHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/bwhm_pkg.sv
// shared types and constants for the barcode whitelist matcher
// no dependencies
package bwhm_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_BASES   = 32;
  localparam int BASES_W         = 64;
  localparam int NMASK_W         = 32;
  localparam int LEN_W           = 6;
  localparam int DIST_W          = 6;
  localparam int CFG_W           = 6;
  localparam int STATUS_W        = 2;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOT_ADD = 2'd3
  } add_status_t;

  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  // normalized word: bases and n mask cleared above the length
  typedef struct packed {
    func_t                func;
    logic [BASES_W-1:0]   bases;
    logic [NMASK_W-1:0]   nmask;
    logic [LEN_W-1:0]     len;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

endpackage

>>> design/bwhm_fifo.sv
// small register queue used between the matcher stages
// depends on nothing
module bwhm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> design/bwhm_front.sv
// front end: saturates length, clears bits above it, queues the word
// depends on bwhm_pkg and bwhm_fifo
module bwhm_front import bwhm_pkg::*; #(
  parameter int MAX_BASES = DEF_MAX_BASES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic [BASES_W-1:0] in_bases,
  input  logic [NMASK_W-1:0] in_n_positions,
  input  logic [LEN_W-1:0]   in_length,
  output logic               item_avail,
  input  logic               item_pop,
  output item_t              item
);

  logic [LEN_W-1:0]   len_sat;
  logic [NMASK_W-1:0] keep;
  item_t              norm;
  logic [ITEM_W-1:0]  q_dout;
  logic               q_empty;

  assign len_sat = (in_length > LEN_W'(MAX_BASES)) ? LEN_W'(MAX_BASES) : in_length;

  always_comb begin
    norm.func = func_t'(in_func);
    norm.len  = len_sat;
    for (int i = 0; i < NMASK_W; i++) begin
      keep[i]            = (LEN_W'(i) < len_sat);
      norm.bases[2*i +: 2] = keep[i] ? in_bases[2*i +: 2] : 2'b00;
      // n positions only count on a lookup
      norm.nmask[i]      = keep[i] && in_n_positions[i] && (norm.func == FUNC_LOOKUP);
    end
  end

  bwhm_fifo #(
    .W     (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (norm),
    .pop   (item_pop),
    .dout  (q_dout),
    .full  (in_full),
    .empty (q_empty)
  );

  assign item_avail = !q_empty;
  assign item       = item_t'(q_dout);

endmodule

>>> design/bwhm_scan.sv
// back end: table memory, entry scan pipeline, best-match tracking
// depends on bwhm_pkg
module bwhm_scan import bwhm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int MAX_BASES   = DEF_MAX_BASES,
  parameter int SLOT_W      = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   max_mm,
  input  logic               item_avail,
  output logic               item_pop,
  input  item_t              item,
  input  logic               out_q_full,
  output logic               res_push,
  output add_status_t        res_status,
  output logic               res_found,
  output logic               res_exact,
  output logic [DIST_W-1:0]  res_dist,
  output logic [BASES_W-1:0] res_bases,
  output logic [SLOT_W-1:0]  res_slot,
  output logic [CNT_W-1:0]   res_count
);

  localparam int BW    = 2 * MAX_BASES;
  localparam int MEM_W = LEN_W + BW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [MEM_W-1:0]  mem [TABLE_DEPTH];
  logic [MEM_W-1:0]  rd_r;
  logic              rd_en, wr_en;

  item_t             q_r;
  logic [SLOT_W-1:0] idx_r;
  logic [CNT_W-1:0]  count_r;

  logic                 v1_r, v2_r, v3_r;
  logic [SLOT_W-1:0]    slot1_r, slot2_r, slot3_r;
  logic [MAX_BASES-1:0] mm, mm_r;
  logic [BW-1:0]        b2_r, b3_r;
  logic [DIST_W-1:0]    d3_r;
  logic [LEN_W-1:0]     ent_len;
  logic [BW-1:0]        ent_bases;
  logic [BW-1:0]        diff;

  logic                 have_r;
  logic [DIST_W-1:0]    best_r;
  logic [SLOT_W-1:0]    bslot_r;
  logic [BW-1:0]        bbases_r;

  logic is_add, hit, near_ok, last_issue, pipe_busy;

  // table memory, one read port and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[SLOT_W-1:0]] <= {q_r.len, q_r.bases[BW-1:0]};
    end
  end

  assign ent_len   = rd_r[MEM_W-1 -: LEN_W];
  assign ent_bases = rd_r[BW-1:0];
  assign diff      = ent_bases ^ q_r.bases[BW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_BASES; i++) begin
      mm[i] = (|diff[2*i +: 2]) || q_r.nmask[i];
    end
  end

  assign last_issue = ((CNT_W'(idx_r) + 1'b1) == count_r);
  assign pipe_busy  = v1_r || v2_r || v3_r;

  // result of the finished scan
  assign is_add  = (q_r.func == FUNC_ADD);
  assign hit     = have_r && (best_r == '0);
  assign near_ok = have_r && (hit || (best_r <= max_mm));

  always_comb begin
    res_status = ST_NOT_ADD;
    res_found  = 1'b0;
    res_exact  = 1'b0;
    res_dist   = '0;
    res_bases  = '0;
    res_slot   = '0;
    res_count  = count_r;
    if (is_add) begin
      if (hit) begin
        res_status = ST_PRESENT;
        res_slot   = bslot_r;
      end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_ADDED;
        res_slot   = count_r[SLOT_W-1:0];
        res_count  = count_r + 1'b1;
      end
    end else if (near_ok) begin
      res_found = 1'b1;
      res_exact = hit;
      res_dist  = best_r;
      res_bases = BASES_W'(bbases_r);
      res_slot  = bslot_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_pop  = 1'b0;
    rd_en     = 1'b0;
    res_push  = 1'b0;
    wr_en     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (item_avail) begin
          item_pop  = 1'b1;
          state_nxt = (count_r != '0) ? S_SCAN : S_DRAIN;
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_q_full) begin
          res_push  = 1'b1;
          wr_en     = (res_status == ST_ADDED);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= rd_en;
      v2_r    <= v1_r && (ent_len == q_r.len);
      v3_r    <= v2_r;
      if (item_pop) begin
        have_r <= 1'b0;
      end else if (v3_r && (!have_r || (d3_r < best_r))) begin
        have_r <= 1'b1;
      end
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // payload registers of the scan pipeline
  always_ff @(posedge clk) begin
    if (item_pop) begin
      q_r   <= item;
      idx_r <= '0;
    end else if (rd_en) begin
      idx_r <= idx_r + 1'b1;
    end
    slot1_r <= idx_r;
    slot2_r <= slot1_r;
    mm_r    <= mm;
    b2_r    <= ent_bases;
    slot3_r <= slot2_r;
    b3_r    <= b2_r;
    d3_r    <= DIST_W'($countones(mm_r));
    // strict compare keeps the earliest slot on a tie
    if (v3_r && (!have_r || (d3_r < best_r))) begin
      best_r   <= d3_r;
      bslot_r  <= slot3_r;
      bbases_r <= b3_r;
    end
  end

endmodule

>>> design/barcode_whitelist_hamming_match_core.sv
// top level of the barcode whitelist matcher with nearest hamming lookup
// depends on bwhm_pkg, bwhm_front, bwhm_scan, bwhm_fifo and the assert header
//
//  channel | handshake        | payload
//  --------+------------------+------------------------------------------------
//  in      | in_push, in_full | in_func, in_bases, in_n_positions, in_length
//  out     | out_pop, out_empty | out_add_status, out_found, out_exact,
//          |                  |   out_distance, out_match_bases, out_match_slot,
//          |                  |   out_entries_held
//  cfg     | cfg_wr_en        | cfg_wr_data (max_mismatches)
//
// in the back end each word is taken from the input queue, then gets one table
// read per stored entry through the single memory read port; the pipeline then
// drains and the result is pushed; with an empty table the reads are skipped
// words are handled one at a time; two-deep queues on both sides let the
// input keep filling and results wait while a scan runs
// reset clears the entry count, queues and control; the table itself is not
// cleared since only slots below the count are ever read
// a full output queue holds the finished result and stalls the next scan
`include "barcode_whitelist_hamming_match_core_assert.svh"

module barcode_whitelist_hamming_match_core import bwhm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int MAX_BASES   = DEF_MAX_BASES,
  parameter int SLOT_W      = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  // input words
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_func,
  input  logic [BASES_W-1:0]  in_bases,
  input  logic [NMASK_W-1:0]  in_n_positions,
  input  logic [LEN_W-1:0]    in_length,
  // result words
  output logic                out_empty,
  input  logic                out_pop,
  output logic [STATUS_W-1:0] out_add_status,
  output logic                out_found,
  output logic                out_exact,
  output logic [DIST_W-1:0]   out_distance,
  output logic [BASES_W-1:0]  out_match_bases,
  output logic [SLOT_W-1:0]   out_match_slot,
  output logic [CNT_W-1:0]    out_entries_held
);

  localparam int RES_W = STATUS_W + 2 + DIST_W + BASES_W + SLOT_W + CNT_W;

  // near-match limit register
  logic [CFG_W-1:0] max_mm_r;

  // front to back
  logic  item_avail;
  logic  item_pop;
  item_t item;

  // back to result queue
  logic               res_push;
  add_status_t        res_status;
  logic               res_found;
  logic               res_exact;
  logic [DIST_W-1:0]  res_dist;
  logic [BASES_W-1:0] res_bases;
  logic [SLOT_W-1:0]  res_slot;
  logic [CNT_W-1:0]   res_count;
  logic               out_q_full;
  logic [RES_W-1:0]   res_din;
  logic [RES_W-1:0]   res_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mm_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      max_mm_r <= cfg_wr_data;
    end
  end

  // normalize and queue incoming words
  bwhm_front #(
    .MAX_BASES (MAX_BASES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_bases       (in_bases),
    .in_n_positions (in_n_positions),
    .in_length      (in_length),
    .item_avail     (item_avail),
    .item_pop       (item_pop),
    .item           (item)
  );

  // scan the table, track the best entry, commit adds
  bwhm_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_BASES   (MAX_BASES),
    .SLOT_W      (SLOT_W),
    .CNT_W       (CNT_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_mm     (max_mm_r),
    .item_avail (item_avail),
    .item_pop   (item_pop),
    .item       (item),
    .out_q_full (out_q_full),
    .res_push   (res_push),
    .res_status (res_status),
    .res_found  (res_found),
    .res_exact  (res_exact),
    .res_dist   (res_dist),
    .res_bases  (res_bases),
    .res_slot   (res_slot),
    .res_count  (res_count)
  );

  // result queue decouples the scan from the consumer
  assign res_din = {res_status, res_found, res_exact, res_dist, res_bases, res_slot, res_count};

  bwhm_fifo #(
    .W     (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_din),
    .pop   (out_pop),
    .dout  (res_dout),
    .full  (out_q_full),
    .empty (out_empty)
  );

  assign {out_add_status, out_found, out_exact, out_distance, out_match_bases,
          out_match_slot, out_entries_held} = res_dout;

  // checks on the scan result path
  `BWHM_ASSERT_SAME(a_no_push_when_full, res_push, !out_q_full, "result pushed into full queue")
  `BWHM_ASSERT_SAME(a_near_within_limit, res_push && res_found && !res_exact,
    (res_dist <= max_mm_r) && (res_dist != '0), "near match outside the limit")
  `BWHM_ASSERT_SAME(a_add_never_found, res_push && (res_status != ST_NOT_ADD),
    !res_found && !res_exact, "add result flagged as a lookup match")
  `BWHM_ASSERT_NEXT(a_pop_on_queue_edge, item_pop, !item_pop, "two words taken back to back")

endmodule

>>> sim/bwhm_match_checker.sv
// result checker for the barcode whitelist matcher: keeps its own copy of the
// barcode table and limit, predicts every accepted word and compares results
// depends on bwhm_pkg
module bwhm_match_checker import bwhm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int SLOT_W      = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_push,
  input  logic                in_full,
  input  logic                in_func,
  input  logic [BASES_W-1:0]  in_bases,
  input  logic [NMASK_W-1:0]  in_n_positions,
  input  logic [LEN_W-1:0]    in_length,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic [STATUS_W-1:0] out_add_status,
  input  logic                out_found,
  input  logic                out_exact,
  input  logic [DIST_W-1:0]   out_distance,
  input  logic [BASES_W-1:0]  out_match_bases,
  input  logic [SLOT_W-1:0]   out_match_slot,
  input  logic [CNT_W-1:0]    out_entries_held,
  output int                  mismatch_total,
  output int                  awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    add_status_t        status;
    logic               found;
    logic               exact;
    logic [DIST_W-1:0]  distance;
    logic [BASES_W-1:0] bases;
    logic [SLOT_W-1:0]  slot;
    logic [CNT_W-1:0]   held;
  } outcome_t;

  logic [BASES_W-1:0] tbl_bases [TABLE_DEPTH];
  logic [LEN_W-1:0]   tbl_len   [TABLE_DEPTH];
  int unsigned        tbl_count = 0;
  logic [CFG_W-1:0]   max_mm = CFG_RESET;
  outcome_t           awaited_results [$];
  int                 failures = 0;

  // both operands already cleared above the length
  function automatic int unsigned base_mismatches(logic [BASES_W-1:0] a,
                                                  logic [BASES_W-1:0] q,
                                                  logic [NMASK_W-1:0] nm);
    logic [BASES_W-1:0] x;
    int unsigned d;
    x = a ^ q;
    d = 0;
    for (int i = 0; i < NMASK_W; i++) begin
      if (nm[i] || x[2*i +: 2] != 2'b00) d++;
    end
    return d;
  endfunction

  // applies one word to the table copy and returns the result it must give
  function automatic outcome_t resolve_word(func_t op, logic [BASES_W-1:0] raw_bases,
                                            logic [NMASK_W-1:0] raw_n,
                                            logic [LEN_W-1:0] raw_len);
    outcome_t r;
    int unsigned len, d, best, bslot;
    logic [BASES_W-1:0] keep, q;
    logic [NMASK_W-1:0] nm;
    bit have, hit;
    r = '0;
    r.status = ST_NOT_ADD;
    len = (raw_len > DEF_MAX_BASES) ? DEF_MAX_BASES : raw_len;
    keep = (len >= 32) ? {BASES_W{1'b1}} : ((64'd1 << (2 * len)) - 64'd1);
    q = raw_bases & keep;
    nm = (len >= 32) ? raw_n : (raw_n & ((32'd1 << len) - 32'd1));
    if (op == FUNC_ADD) begin
      r.status = ST_ADDED;
      hit = 1'b0;
      for (int unsigned i = 0; i < tbl_count && !hit; i++) begin
        if (tbl_len[i] == len && tbl_bases[i] == q) begin
          hit = 1'b1;
          r.status = ST_PRESENT;
          r.slot = SLOT_W'(i);
        end
      end
      if (!hit) begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.slot = SLOT_W'(tbl_count);
          tbl_bases[tbl_count] = q;
          tbl_len[tbl_count] = LEN_W'(len);
          tbl_count++;
        end
      end
    end else begin
      have = 1'b0;
      best = 0;
      bslot = 0;
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (tbl_len[i] == len) begin
          d = base_mismatches(tbl_bases[i], q, nm);
          // strict compare keeps the earliest slot on a tie
          if (!have || d < best) begin
            have = 1'b1;
            best = d;
            bslot = i;
          end
        end
      end
      if (have && (best == 0 || best <= max_mm)) begin
        r.found = 1'b1;
        r.exact = (best == 0);
        r.distance = DIST_W'(best);
        r.slot = SLOT_W'(bslot);
        r.bases = tbl_bases[bslot];
      end
    end
    r.held = CNT_W'(tbl_count);
    return r;
  endfunction

  function automatic void check_field(string name, logic [BASES_W-1:0] want,
                                      logic [BASES_W-1:0] got);
    if (want !== got) begin
      failures++;
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst_n) begin
      tbl_count = 0;
      max_mm = CFG_RESET;
      awaited_results.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (awaited_results.size() == 0) begin
          failures++;
          $error("result word with no word awaiting it");
        end else begin
          want = awaited_results.pop_front();
          check_field("add_status", BASES_W'(want.status), BASES_W'(out_add_status));
          check_field("found", BASES_W'(want.found), BASES_W'(out_found));
          check_field("exact", BASES_W'(want.exact), BASES_W'(out_exact));
          check_field("distance", BASES_W'(want.distance), BASES_W'(out_distance));
          check_field("match_bases", want.bases, out_match_bases);
          check_field("match_slot", BASES_W'(want.slot), BASES_W'(out_match_slot));
          check_field("entries_held", BASES_W'(want.held), BASES_W'(out_entries_held));
        end
      end
      if (cfg_wr_en) max_mm = cfg_wr_data;
      if (in_push && !in_full) begin
        awaited_results.push_back(resolve_word(func_t'(in_func), in_bases,
                                               in_n_positions, in_length));
      end
    end
    mismatch_total <= failures;
    awaited_count <= awaited_results.size();
  end

endmodule

>>> sim/testbench.sv
// top of the barcode whitelist matcher simulation: clock, reset, stimulus
// and verdict; checking is done by bwhm_match_checker
// depends on bwhm_pkg, bwhm_match_checker and the matcher rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bwhm_pkg::*;

  localparam int SLOT_W = $clog2(DEF_TABLE_DEPTH);
  localparam int CNT_W  = $clog2(DEF_TABLE_DEPTH + 1);
  localparam logic [BASES_W-1:0] ALL_T = {BASES_W{1'b1}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic                in_func = 1'b0;
  logic [BASES_W-1:0]  in_bases = '0;
  logic [NMASK_W-1:0]  in_n_positions = '0;
  logic [LEN_W-1:0]    in_length = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [STATUS_W-1:0] out_add_status;
  logic                out_found;
  logic                out_exact;
  logic [DIST_W-1:0]   out_distance;
  logic [BASES_W-1:0]  out_match_bases;
  logic [SLOT_W-1:0]   out_match_slot;
  logic [CNT_W-1:0]    out_entries_held;

  int mismatch_total;
  int awaited_count;

  // when set, neither side idles
  bit calm = 1'b0;

  // every barcode ever pushed as an add, raw; lookups and duplicates are
  // derived from these so that most lookups land on real entries
  logic [BASES_W-1:0] pool_bases [$];
  logic [LEN_W-1:0]   pool_len   [$];

  barcode_whitelist_hamming_match_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_func          (in_func),
    .in_bases         (in_bases),
    .in_n_positions   (in_n_positions),
    .in_length        (in_length),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_add_status   (out_add_status),
    .out_found        (out_found),
    .out_exact        (out_exact),
    .out_distance     (out_distance),
    .out_match_bases  (out_match_bases),
    .out_match_slot   (out_match_slot),
    .out_entries_held (out_entries_held)
  );

  bwhm_match_checker match_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_func          (in_func),
    .in_bases         (in_bases),
    .in_n_positions   (in_n_positions),
    .in_length        (in_length),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_add_status   (out_add_status),
    .out_found        (out_found),
    .out_exact        (out_exact),
    .out_distance     (out_distance),
    .out_match_bases  (out_match_bases),
    .out_match_slot   (out_match_slot),
    .out_entries_held (out_entries_held),
    .mismatch_total   (mismatch_total),
    .awaited_count    (awaited_count)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // result side: pop held low about 8 percent of the time, never while calm
  always @(posedge clk) begin
    out_pop <= calm || ($urandom_range(99) >= 8);
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // one word onto the input queue; returns at the edge that accepts it and
  // leaves push high so back-to-back words need no second assignment
  task automatic push_word(func_t op, logic [BASES_W-1:0] b, logic [NMASK_W-1:0] n,
                           logic [LEN_W-1:0] l);
    while (!calm && $urandom_range(99) < 8) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_func <= op;
    in_bases <= b;
    in_n_positions <= n;
    in_length <= l;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (op == FUNC_ADD) begin
      pool_bases.push_back(b);
      pool_len.push_back(l);
    end
  endtask

  // stop sending and wait until every awaited result word has been popped;
  // the extra edge lets the checker count the last accepted word
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
  endtask

  // limit changes only with the block idle
  task automatic set_limit(logic [CFG_W-1:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // fresh junk above the length, then a few substituted bases inside it
  function automatic logic [BASES_W-1:0] perturb_barcode(logic [BASES_W-1:0] b,
                                                         logic [LEN_W-1:0] l, int flips);
    int eff, p;
    logic [BASES_W-1:0] keep;
    eff = (l > 32) ? 32 : l;
    if (eff < 32) begin
      keep = (64'd1 << (2 * eff)) - 64'd1;
      b = (b & keep) | ({$urandom, $urandom} & ~keep);
    end
    for (int j = 0; j < flips && eff > 0; j++) begin
      p = $urandom_range(eff - 1);
      b[2*p +: 2] = b[2*p +: 2] ^ 2'($urandom_range(1, 3));
    end
    return b;
  endfunction

  initial begin
    logic [BASES_W-1:0] b;
    logic [NMASK_W-1:0] n;
    logic [LEN_W-1:0]   l;
    logic [CFG_W-1:0]   lim;
    int roll, pick, eff;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset limit of one ----
    // lookup into an empty table
    push_word(FUNC_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, 6'd8);
    // empty barcodes: all identical whatever the junk in the bases
    push_word(FUNC_ADD, 64'h5555_AAAA_5555_AAAA, '0, 6'd0);
    push_word(FUNC_ADD, 64'h1234_5678_9ABC_DEF0, '1, 6'd0);
    push_word(FUNC_LOOKUP, 64'hFFFF_0000_FFFF_0000, '0, 6'd0);
    // full length all T, then the same with the length over the maximum
    push_word(FUNC_ADD, ALL_T, '0, 6'd32);
    push_word(FUNC_ADD, ALL_T, '1, 6'd63);
    push_word(FUNC_ADD, '0, '0, 6'd32);
    push_word(FUNC_LOOKUP, ALL_T, '0, 6'd32);
    // an N in the top position: near match at one
    push_word(FUNC_LOOKUP, ALL_T, 32'h8000_0000, 6'd32);
    // two Ns: beyond the limit
    push_word(FUNC_LOOKUP, ALL_T, 32'h0000_0003, 6'd32);
    // short barcode ACGT with junk above the length, N mask ignored on adds
    push_word(FUNC_ADD, 64'h5A5A_5A5A_5A5A_5AE4, '0, 6'd4);
    push_word(FUNC_ADD, 64'hA5A5_A5A5_A5A5_A5E4, '1, 6'd4);
    push_word(FUNC_ADD, 64'h0000_0000_0000_00E5, '0, 6'd4);
    // one base off both entries: tie goes to the older slot
    push_word(FUNC_LOOKUP, 64'h0000_0000_0000_00E6, '0, 6'd4);
    // N bit above the length is ignored, exact hit
    push_word(FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFE4, 32'hFFFF_FFE0, 6'd4);
    // N on the first base: distance one to both, older slot wins
    push_word(FUNC_LOOKUP, 64'h0000_0000_0000_00E4, 32'h0000_0001, 6'd4);
    // no entry of this length
    push_word(FUNC_LOOKUP, 64'h0000_0000_0000_00E4, '0, 6'd5);
    // exact only: the tie case now finds nothing
    set_limit(6'd0);
    push_word(FUNC_LOOKUP, 64'h0000_0000_0000_00E6, '0, 6'd4);

    // ---- random part, one phase per limit setting ----
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       lim = 6'd0;
        1:       lim = 6'd3;
        2:       lim = 6'd32;
        3:       lim = 6'd63;
        default: lim = 6'd1;
      endcase
      set_limit(lim);
      for (int k = 0; k < 111; k++) begin
        // one long stretch with no idling on either side
        calm = (ph == 2 && k < 70);
        // now and then let the block run dry before the next word
        if ($urandom_range(199) == 0) drain();
        roll = $urandom_range(99);
        n = $urandom;
        if (pool_len.size() == 0 || roll < 14) begin
          // new barcode, lengths clustered so that entries collide and tie
          pick = $urandom_range(99);
          if (pick < 40) l = 6'd4;
          else if (pick < 55) l = 6'd8;
          else if (pick < 65) l = 6'd32;
          else if (pick < 68) l = 6'd0;
          else if (pick < 72) l = LEN_W'($urandom_range(33, 63));
          else l = LEN_W'($urandom_range(1, 32));
          push_word(FUNC_ADD, {$urandom, $urandom}, n, l);
        end else if (roll < 94) begin
          pick = $urandom_range(pool_len.size() - 1);
          l = pool_len[pick];
          b = pool_bases[pick];
          // a full-length barcode may be given with any oversized length
          if (l >= 32 && $urandom_range(1) == 1) l = LEN_W'($urandom_range(32, 63));
          if (roll < 24) begin
            // repeat of a stored barcode
            push_word(FUNC_ADD, perturb_barcode(b, l, 0), n, l);
          end else if (roll < 34) begin
            // close neighbour, makes for near ties later
            push_word(FUNC_ADD, perturb_barcode(b, l, $urandom_range(1, 2)), n, l);
          end else begin
            // lookup near a stored barcode, sometimes with Ns inside
            eff = (l > 32) ? 32 : l;
            if (eff < 32) n = n & ~((32'd1 << eff) - 32'd1);
            if (eff > 0 && $urandom_range(3) == 0) n[$urandom_range(eff - 1)] = 1'b1;
            if (eff > 0 && $urandom_range(7) == 0) n[$urandom_range(eff - 1)] = 1'b1;
            pick = ($urandom_range(3) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 2);
            push_word(FUNC_LOOKUP, perturb_barcode(b, l, pick), n, l);
          end
        end else begin
          // noise lookup
          push_word(FUNC_LOOKUP, {$urandom, $urandom}, n, LEN_W'($urandom_range(63)));
        end
      end
    end
    calm = 1'b0;

    // ---- limits around the full base count ----
    // all positions N: distance 32 everywhere, over the limit of five
    set_limit(6'd5);
    push_word(FUNC_LOOKUP, ALL_T, '1, 6'd32);
    // limit above the base count accepts any equal-length entry
    set_limit(6'd63);
    push_word(FUNC_LOOKUP, ALL_T, '1, 6'd32);

    // ---- wind down ----
    drain();
    repeat (1100) @(posedge clk);
    if (mismatch_total == 0 && awaited_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
